// File: rtl/core/llt_pkg.sv
// Shared types and constants of the LCD line timing controller.
// Used by llt_sprite_scan and lcd_line_timing_controller; depends on nothing.
package llt_pkg;

  // Default sizes of the sprite-Y store and of the per-line sprite limit.
  localparam int SPRITE_SLOTS_DEF = 40;
  localparam int MAX_SPRITES_DEF  = 10;

  // Width of the sprite slot field of an input beat.
  localparam int SLOT_FIELD_W = 6;

  // Line timing constants.
  localparam logic [9:0] LINE_CYCLES   = 10'd456;
  localparam logic [9:0] SCAN_CYCLES   = 10'd80;
  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] LAST_LINE     = 8'd153;
  localparam logic [8:0] XFER_BASE     = 9'd172;
  localparam logic [8:0] XFER_MAX      = 9'd291;
  localparam logic [8:0] Y_OFFSET      = 9'd16;
  localparam logic [8:0] SPRITE_SHORT  = 9'd8;
  localparam logic [8:0] SPRITE_TALL   = 9'd16;

  // Status mode codes.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_LCD_CONTROL  = 2'd0;
  localparam logic [1:0] REG_FINE_SCROLL  = 2'd1;
  localparam logic [1:0] REG_LINE_COMPARE = 2'd2;
  localparam logic [1:0] REG_STAT_ENABLES = 2'd3;

  // Input beat kinds carried on tuser.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Bit positions inside lcd_control and stat_enables.
  localparam int LCDC_ENABLE_BIT  = 7;
  localparam int LCDC_SPRITES_BIT = 1;
  localparam int LCDC_TALL_BIT    = 2;
  localparam int STAT_HBLANK_BIT  = 0;
  localparam int STAT_VBLANK_BIT  = 1;
  localparam int STAT_OAM_BIT     = 2;
  localparam int STAT_MATCH_BIT   = 3;

  // Request from the timing sequencer to the sprite scan unit.
  typedef struct packed {
    logic       start;
    logic [7:0] line;
    logic       shown;
    logic       tall;
    logic [2:0] fine;
  } scan_req_t;

  // Answer of the sprite scan unit.
  typedef struct packed {
    logic       done;
    logic [8:0] length;
  } scan_rsp_t;

endpackage

// File: rtl/core/llt_sprite_scan.sv
// Sprite-Y store and the transfer length scanner of the LCD line timing controller.
// One comparator walks the store one slot a cycle. Depends on llt_pkg.
module llt_sprite_scan #(
  parameter int SPRITE_SLOTS         = llt_pkg::SPRITE_SLOTS_DEF,
  parameter int MAX_SPRITES_PER_LINE = llt_pkg::MAX_SPRITES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  llt_pkg::scan_req_t                req_i,
  output llt_pkg::scan_rsp_t                rsp_o,
  input  logic                              wr_en_i,
  input  logic [llt_pkg::SLOT_FIELD_W-1:0]  wr_slot_i,
  input  logic [7:0]                        wr_y_i
);
  import llt_pkg::*;

  localparam int SLOT_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(SPRITE_SLOTS + 1);
  localparam int HIT_W  = $clog2(MAX_SPRITES_PER_LINE + 1);
  localparam logic [CNT_W-1:0]        SLOT_END  = CNT_W'(SPRITE_SLOTS);
  localparam logic [HIT_W-1:0]        HIT_LIMIT = HIT_W'(MAX_SPRITES_PER_LINE);
  localparam logic [SLOT_FIELD_W:0]   SLOTS_EXT = (SLOT_FIELD_W + 1)'(SPRITE_SLOTS);

  logic [7:0]              y_mem [SPRITE_SLOTS];
  logic [SPRITE_SLOTS-1:0] valid_r;
  logic [7:0]              rd_y_r;
  logic                    rd_ok_r;

  logic                    running_r, running_nxt;
  logic                    pend_r, pend_nxt;
  logic [CNT_W-1:0]        addr_r, addr_nxt;
  logic [HIT_W-1:0]        hits_r, hits_nxt;
  logic [7:0]              line_r, line_nxt;
  logic                    shown_r, shown_nxt;
  logic                    tall_r, tall_nxt;
  logic [2:0]              fine_r, fine_nxt;
  logic                    done_r, done_nxt;
  logic [8:0]              len_r, len_nxt;

  logic                    wr_ok;
  logic [SLOT_W-1:0]       wr_idx;
  logic [SLOT_W-1:0]       rd_idx;
  logic                    issue;
  logic                    finish;
  logic [8:0]              row;
  logic [8:0]              y_ext;
  logic [8:0]              height;
  logic                    hit;
  logic [8:0]              len_raw;

  assign wr_ok  = wr_en_i && ({1'b0, wr_slot_i} < SLOTS_EXT);
  assign wr_idx = wr_slot_i[SLOT_W-1:0];
  assign rd_idx = addr_r[SLOT_W-1:0];
  assign issue  = running_r && (addr_r != SLOT_END);
  assign finish = running_r && !issue && !pend_r;

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      y_mem[wr_idx] <= wr_y_i;
    end
    if (issue) begin
      rd_y_r  <= y_mem[rd_idx];
      rd_ok_r <= valid_r[rd_idx];
    end
  end

  // An entry that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ok) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // Sprite on the line when row - y lies in [0, height).
  assign row    = {1'b0, line_r} + Y_OFFSET;
  assign y_ext  = {1'b0, (rd_ok_r ? rd_y_r : 8'd0)};
  assign height = tall_r ? SPRITE_TALL : SPRITE_SHORT;
  assign hit    = (y_ext <= row) && (row < (y_ext + height));

  assign len_raw = XFER_BASE + {6'd0, fine_r} +
                   (shown_r ? (9'(hits_r) << 1) : 9'd0);

  always_comb begin
    running_nxt = running_r;
    pend_nxt    = 1'b0;
    addr_nxt    = addr_r;
    hits_nxt    = hits_r;
    line_nxt    = line_r;
    shown_nxt   = shown_r;
    tall_nxt    = tall_r;
    fine_nxt    = fine_r;
    done_nxt    = 1'b0;
    len_nxt     = len_r;
    if (req_i.start) begin
      running_nxt = 1'b1;
      addr_nxt    = '0;
      hits_nxt    = '0;
      line_nxt    = req_i.line;
      shown_nxt   = req_i.shown;
      tall_nxt    = req_i.tall;
      fine_nxt    = req_i.fine;
    end else if (running_r) begin
      if (issue) begin
        pend_nxt = 1'b1;
        addr_nxt = addr_r + CNT_W'(1);
      end
      if (pend_r && hit && (hits_r != HIT_LIMIT)) begin
        hits_nxt = hits_r + HIT_W'(1);
      end
      if (finish) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
        len_nxt     = (len_raw > XFER_MAX) ? XFER_MAX : len_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pend_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      pend_r    <= pend_nxt;
      done_r    <= done_nxt;
    end
    addr_r  <= addr_nxt;
    hits_r  <= hits_nxt;
    line_r  <= line_nxt;
    shown_r <= shown_nxt;
    tall_r  <= tall_nxt;
    fine_r  <= fine_nxt;
    len_r   <= len_nxt;
  end

  assign rsp_o.done   = done_r;
  assign rsp_o.length = len_r;

endmodule

// File: rtl/core/lcd_line_timing_controller.sv
// Top level of the LCD line timing controller: line and mode sequencer,
// status publishing, interrupt pulses and output register. Depends on llt_pkg
// and llt_sprite_scan.
//
// The block keeps a line cycle counter that wraps at LINE_CYCLES, over 154 lines
// of a frame. Each input beat carries either a tick (tuser 0), which adds elapsed
// clock cycles and moves the line and mode, or a sprite-Y write (tuser 1), which
// loads one slot of the sprite-Y store. Every input beat produces exactly one
// output beat with the current line, the published status mode and line-match
// flag, and the STAT, vertical-blank and render-start pulses. Items are handled
// one at a time: in_tready is high only while the sequencer is idle. A tick that
// ends a visible line, starts a transfer, or wraps the frame runs the sprite scan,
// which walks the store one slot per cycle through a single comparator over the
// store's single read port. The finished result sits in an output register, so
// the next beat is accepted while it waits for out_tready; the sequencer stalls
// only when a new result is ready and the register is still full. The sprite
// store clears at reset through per-slot valid bits, so no clearing pass is
// needed. Configuration registers are written through the cfg_ port; the user
// must write them only while no item is in flight; the block itself does not
// enforce it.
module lcd_line_timing_controller #(
  parameter int SPRITE_SLOTS         = llt_pkg::SPRITE_SLOTS_DEF,
  parameter int MAX_SPRITES_PER_LINE = llt_pkg::MAX_SPRITES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // elapsed_cycles[7:0], sprite_slot[13:8], y_pos[21:14]
  input  logic        in_tuser,   // action: 0 tick, 1 sprite-Y write
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // line_number[7:0], status_mode[9:8], line_match[10],
                                  // stat_irq[11], vblank_irq[12], render_start[13]
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wr_data
);
  import llt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SCAN, S_PUB} state_t;

  // Configuration registers.
  logic [7:0] lcd_ctrl_r;
  logic [2:0] fine_x_r;
  logic [7:0] lyc_r;
  logic [3:0] stat_en_r;

  // Timing state.
  state_t     state_r, state_nxt;
  logic [9:0] cycle_r, cycle_nxt;
  logic [7:0] line_r, line_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [8:0] xfer_len_r, xfer_len_nxt;
  logic [2:0] pub_r, pub_nxt;
  logic       stat_lvl_r, stat_lvl_nxt;
  logic       lcd_on_r, lcd_on_nxt;

  // Per-item working registers.
  logic [9:0] sum_r, sum_nxt;
  logic       early_r, early_nxt;
  logic       do_pub_r, do_pub_nxt;
  logic       vbl_p_r, vbl_p_nxt;
  logic       rend_p_r, rend_p_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_line_r, out_line_nxt;
  logic [1:0] out_mode_r, out_mode_nxt;
  logic       out_match_r, out_match_nxt;
  logic       out_stat_r, out_stat_nxt;
  logic       out_vbl_r, out_vbl_nxt;
  logic       out_rend_r, out_rend_nxt;

  scan_req_t  scan_req;
  scan_rsp_t  scan_rsp;
  logic       store_wr;

  logic       in_fire;
  logic       out_free;
  logic [9:0] base;
  logic       line_end;
  logic       match;
  logic       stat_sig;
  logic [2:0] pub_val;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign base      = lcd_on_r ? cycle_r : 10'd0;
  assign line_end  = (sum_r >= LINE_CYCLES);

  // Combined status interrupt line for the line and mode now current.
  assign match    = (line_r == lyc_r);
  assign stat_sig = (match && stat_en_r[STAT_MATCH_BIT]) ||
                    ((mode_r == MODE_HBLANK) && stat_en_r[STAT_HBLANK_BIT]) ||
                    ((mode_r == MODE_VBLANK) && stat_en_r[STAT_VBLANK_BIT]) ||
                    ((mode_r == MODE_OAM) && stat_en_r[STAT_OAM_BIT]);
  assign pub_val  = do_pub_r ? {match, mode_r} : pub_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_ctrl_r <= 8'd0;
      fine_x_r   <= 3'd0;
      lyc_r      <= 8'd0;
      stat_en_r  <= 4'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LCD_CONTROL:  lcd_ctrl_r <= cfg_wr_data;
        REG_FINE_SCROLL:  fine_x_r   <= cfg_wr_data[2:0];
        REG_LINE_COMPARE: lyc_r      <= cfg_wr_data;
        REG_STAT_ENABLES: stat_en_r  <= cfg_wr_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accept, evaluate the tick, optionally scan sprites, publish.
  always_comb begin
    state_nxt     = state_r;
    cycle_nxt     = cycle_r;
    line_nxt      = line_r;
    mode_nxt      = mode_r;
    xfer_len_nxt  = xfer_len_r;
    pub_nxt       = pub_r;
    stat_lvl_nxt  = stat_lvl_r;
    lcd_on_nxt    = lcd_on_r;
    sum_nxt       = sum_r;
    early_nxt     = early_r;
    do_pub_nxt    = do_pub_r;
    vbl_p_nxt     = vbl_p_r;
    rend_p_nxt    = rend_p_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_line_nxt  = out_line_r;
    out_mode_nxt  = out_mode_r;
    out_match_nxt = out_match_r;
    out_stat_nxt  = out_stat_r;
    out_vbl_nxt   = out_vbl_r;
    out_rend_nxt  = out_rend_r;
    store_wr      = 1'b0;
    scan_req.start = 1'b0;
    scan_req.line  = line_r;
    scan_req.shown = lcd_ctrl_r[LCDC_SPRITES_BIT];
    scan_req.tall  = lcd_ctrl_r[LCDC_TALL_BIT];
    scan_req.fine  = fine_x_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          do_pub_nxt = 1'b0;
          vbl_p_nxt  = 1'b0;
          rend_p_nxt = 1'b0;
          if (in_tuser == ACT_WRITE) begin
            store_wr  = 1'b1;
            state_nxt = S_PUB;
          end else if (!lcd_ctrl_r[LCDC_ENABLE_BIT]) begin
            // First tick with the LCD off parks the timing; later ones do nothing.
            if (lcd_on_r) begin
              line_nxt   = 8'd0;
              mode_nxt   = MODE_HBLANK;
              cycle_nxt  = 10'd0;
              lcd_on_nxt = 1'b0;
            end
            state_nxt = S_PUB;
          end else begin
            // Turning the LCD on restarts the frame at line 0.
            if (!lcd_on_r) begin
              lcd_on_nxt = 1'b1;
              line_nxt   = 8'd0;
              mode_nxt   = MODE_OAM;
            end
            sum_nxt   = base + 10'(in_tdata[7:0]);
            early_nxt = (base < SCAN_CYCLES);
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        do_pub_nxt = 1'b1;
        state_nxt  = S_PUB;
        if (line_r < VISIBLE_LINES) begin
          if (line_end) begin
            // Length is recomputed for the line just finished.
            cycle_nxt      = sum_r - LINE_CYCLES;
            scan_req.start = 1'b1;
            line_nxt       = line_r + 8'd1;
            if ((line_r + 8'd1) == VISIBLE_LINES) begin
              mode_nxt  = MODE_VBLANK;
              vbl_p_nxt = 1'b1;
            end else begin
              mode_nxt = MODE_OAM;
            end
            state_nxt = S_SCAN;
          end else begin
            cycle_nxt = sum_r;
            if (sum_r < SCAN_CYCLES) begin
              mode_nxt = MODE_OAM;
            end else if (sum_r < (SCAN_CYCLES + {1'b0, xfer_len_r})) begin
              mode_nxt = MODE_XFER;
              if (early_r) begin
                scan_req.start = 1'b1;
                rend_p_nxt     = 1'b1;
                state_nxt      = S_SCAN;
              end
            end else begin
              // Includes a tick that jumps over the whole transfer.
              mode_nxt = MODE_HBLANK;
            end
          end
        end else if (line_end) begin
          cycle_nxt = sum_r - LINE_CYCLES;
          if (line_r == LAST_LINE) begin
            // Frame wrap: line 0 gets its transfer length up front.
            line_nxt       = 8'd0;
            mode_nxt       = MODE_OAM;
            scan_req.start = 1'b1;
            scan_req.line  = 8'd0;
            state_nxt      = S_SCAN;
          end else begin
            line_nxt = line_r + 8'd1;
            mode_nxt = MODE_VBLANK;
          end
        end else begin
          // Vertical blank tick inside a line publishes nothing.
          cycle_nxt  = sum_r;
          do_pub_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (scan_rsp.done) begin
          xfer_len_nxt = scan_rsp.length;
          state_nxt    = S_PUB;
        end
      end
      S_PUB: begin
        if (out_free) begin
          pub_nxt = pub_val;
          if (do_pub_r) begin
            stat_lvl_nxt = stat_sig;
          end
          out_valid_nxt = 1'b1;
          out_line_nxt  = line_r;
          out_mode_nxt  = pub_val[1:0];
          out_match_nxt = pub_val[2];
          out_stat_nxt  = do_pub_r && stat_sig && !stat_lvl_r;
          out_vbl_nxt   = vbl_p_r;
          out_rend_nxt  = rend_p_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cycle_r     <= 10'd0;
      line_r      <= 8'd0;
      mode_r      <= MODE_OAM;
      xfer_len_r  <= 9'd0;
      pub_r       <= 3'd0;
      stat_lvl_r  <= 1'b0;
      lcd_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cycle_r     <= cycle_nxt;
      line_r      <= line_nxt;
      mode_r      <= mode_nxt;
      xfer_len_r  <= xfer_len_nxt;
      pub_r       <= pub_nxt;
      stat_lvl_r  <= stat_lvl_nxt;
      lcd_on_r    <= lcd_on_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sum_r       <= sum_nxt;
    early_r     <= early_nxt;
    do_pub_r    <= do_pub_nxt;
    vbl_p_r     <= vbl_p_nxt;
    rend_p_r    <= rend_p_nxt;
    out_line_r  <= out_line_nxt;
    out_mode_r  <= out_mode_nxt;
    out_match_r <= out_match_nxt;
    out_stat_r  <= out_stat_nxt;
    out_vbl_r   <= out_vbl_nxt;
    out_rend_r  <= out_rend_nxt;
  end

  llt_sprite_scan #(
    .SPRITE_SLOTS         (SPRITE_SLOTS),
    .MAX_SPRITES_PER_LINE (MAX_SPRITES_PER_LINE)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (scan_req),
    .rsp_o     (scan_rsp),
    .wr_en_i   (store_wr),
    .wr_slot_i (in_tdata[13:8]),
    .wr_y_i    (in_tdata[21:14])
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rend_r, out_vbl_r, out_stat_r, out_match_r,
                       out_mode_r, out_line_r};

  // A render-start beat always reports the transfer mode.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rend_r) |-> (out_mode_r == MODE_XFER))
    else $error("render start without transfer mode");

  // The vertical-blank pulse comes only with line 144 in vertical blank.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vbl_r) |->
      ((out_line_r == VISIBLE_LINES) && (out_mode_r == MODE_VBLANK)))
    else $error("vblank pulse on wrong line or mode");

  // The scan unit only answers while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    scan_rsp.done |-> (state_r == S_SCAN))
    else $error("sprite scan finished outside the scan state");

  // The line counter never leaves the frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= LAST_LINE)
    else $error("line counter out of range");

endmodule
